// ===== rtl/core/pcxrle_pkg.sv =====
// Shared types, constants and helpers for the PCX run-length palette decoder.
// Used by every module under rtl/core but pcxrle_ram; depends on nothing else.
`default_nettype none

package pcxrle_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int PALETTE_WIDTH   = 24;
   localparam int PAL_ADDR_W      = $clog2(PALETTE_ENTRIES);
   localparam int MAX_RUN         = 63;
   localparam int RUN_W           = $clog2(MAX_RUN + 1);

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 104;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 19;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_LINE_BYTES  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_FORMAT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_LINE_BYTES = 3'd4;

   // Pixel formats.
   localparam logic [1:0] FMT_RGB565 = 2'd0;
   localparam logic [1:0] FMT_BGR    = 2'd1;
   localparam logic [1:0] FMT_RGB0   = 2'd2;
   localparam logic [1:0] FMT_BAD    = 2'd3;

   typedef enum logic [1:0] {
      FUNC_PALETTE = 2'd0,
      FUNC_START   = 2'd1,
      FUNC_DATA    = 2'd2,
      FUNC_END     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STAT_NONE       = 3'd0,
      STAT_BAD_GEOM   = 3'd1,
      STAT_ZERO_RUN   = 3'd2,
      STAT_OVERRUN    = 3'd3,
      STAT_EXTRA_DATA = 3'd4,
      STAT_CUT_RUN    = 3'd5,
      STAT_EARLY_END  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_EXPAND = 2'd1,
      S_FLUSH  = 2'd2
   } state_type;

   typedef struct packed {
      logic [16:0] image_width;
      logic [16:0] image_height;
      logic [15:0] src_line_bytes;
      logic [1:0]  pixel_format;
      logic [18:0] dest_line_bytes;
      logic        geom_bad;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] pixel_bytes;
      logic [2:0]  byte_count;
      logic [15:0] row;
      logic [15:0] column;
      logic [31:0] byte_offset;
      status_type  status;
      logic        last;
   } rsp_type;

   // Bytes per destination pixel; the unused format code behaves as RGB0.
   function automatic logic [2:0] dest_pixel_bytes(input logic [1:0] fmt);
      logic [2:0] bpp;
      case (fmt)
         FMT_RGB565: bpp = 3'd2;
         FMT_BGR:    bpp = 3'd3;
         default:    bpp = 3'd4;
      endcase
      return bpp;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pcxrle_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module pcxrle_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pcxrle_csr.sv =====
// Configuration registers of the decoder and the image geometry check.
// Depends on pcxrle_pkg.
`default_nettype none

module pcxrle_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [pcxrle_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [pcxrle_pkg::CSR_DATA_W-1:0]    csr_data,
   output pcxrle_pkg::cfg_type                       cfg
);

   logic [16:0] width_ff;
   logic [16:0] height_ff;
   logic [15:0] src_ff;
   logic [1:0]  fmt_ff;
   logic [18:0] dest_ff;
   logic [18:0] row_bytes;
   logic        geom_bad;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 17'd1;
         height_ff <= 17'd1;
         src_ff    <= 16'd1;
         fmt_ff    <= pcxrle_pkg::FMT_RGB0;
         dest_ff   <= 19'd4;
      end else if (csr_valid) begin
         unique case (csr_index)
            pcxrle_pkg::CSR_IMAGE_WIDTH:     width_ff  <= csr_data[16:0];
            pcxrle_pkg::CSR_IMAGE_HEIGHT:    height_ff <= csr_data[16:0];
            pcxrle_pkg::CSR_SRC_LINE_BYTES:  src_ff    <= csr_data[15:0];
            pcxrle_pkg::CSR_PIXEL_FORMAT:    fmt_ff    <= csr_data[1:0];
            pcxrle_pkg::CSR_DEST_LINE_BYTES: dest_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Width in destination bytes; at most 131071 times four, so 19 bits suffice.
   always_comb begin
      case (fmt_ff)
         pcxrle_pkg::FMT_RGB565: row_bytes = {1'b0, width_ff, 1'b0};
         pcxrle_pkg::FMT_BGR:    row_bytes = {1'b0, width_ff, 1'b0} + {2'b00, width_ff};
         default:                row_bytes = {width_ff, 2'b00};
      endcase
   end

   always_comb begin
      geom_bad = (width_ff == 17'd0) || (width_ff[16] && (width_ff[15:0] != 16'd0)) ||
                 (height_ff == 17'd0) || (height_ff[16] && (height_ff[15:0] != 16'd0)) ||
                 (src_ff == 16'd0) || ({1'b0, src_ff} < width_ff) ||
                 (fmt_ff == pcxrle_pkg::FMT_BAD) || (row_bytes > dest_ff);
   end

   always_comb begin
      cfg.image_width     = width_ff;
      cfg.image_height    = height_ff;
      cfg.src_line_bytes  = src_ff;
      cfg.pixel_format    = fmt_ff;
      cfg.dest_line_bytes = dest_ff;
      cfg.geom_bad        = geom_bad;
   end

endmodule

`default_nettype wire

// ===== rtl/core/pcxrle_engine.sv =====
// Decode engine: palette memory, position counters, run expansion and a
// one-deep result hold that lets the last result of a request be marked.
// Depends on pcxrle_pkg and pcxrle_ram.
`default_nettype none

module pcxrle_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire pcxrle_pkg::func_type              func,
   input  wire logic [7:0]                        data_byte,
   input  wire logic [pcxrle_pkg::PAL_ADDR_W-1:0] palette_index,
   input  wire logic [pcxrle_pkg::PALETTE_WIDTH-1:0] palette_rgb,
   input  wire pcxrle_pkg::cfg_type               cfg,
   input  wire logic                              out_free,
   output logic                                   res_valid,
   output pcxrle_pkg::rsp_type                    res
);

   pcxrle_pkg::state_type state_ff, state_in;
   logic [16:0] row_ff, row_in;
   logic [15:0] col_ff, col_in;
   logic [31:0] base_ff, base_in;
   logic        await_ff, await_in;
   logic [pcxrle_pkg::RUN_W-1:0] run_ff, run_in;
   logic [pcxrle_pkg::RUN_W-1:0] remain_ff, remain_in;
   logic        sticky_ff, sticky_in;
   pcxrle_pkg::rsp_type hold_ff, hold_in;
   logic        hold_vld_ff, hold_vld_in;

   logic        rd_en;
   logic [pcxrle_pkg::PALETTE_WIDTH-1:0] rd_data;
   logic        accept;
   logic        rows_done;
   logic        visible;
   logic        step_has_res;
   logic [15:0] col_next;
   logic [17:0] col_bytes;
   pcxrle_pkg::rsp_type pixel_res;

   pcxrle_ram #(
      .WIDTH (pcxrle_pkg::PALETTE_WIDTH),
      .DEPTH (pcxrle_pkg::PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (accept && (func == pcxrle_pkg::FUNC_PALETTE)),
      .wr_addr (palette_index),
      .wr_data (palette_rgb),
      .rd_en   (rd_en),
      .rd_addr (data_byte),
      .rd_data (rd_data)
   );

   function automatic logic [31:0] format_pixel(input logic [23:0] rgb, input logic [1:0] fmt);
      logic [31:0] pix;
      case (fmt)
         pcxrle_pkg::FMT_RGB565: pix = {16'h0000, rgb[23:19], rgb[15:10], rgb[7:3]};
         pcxrle_pkg::FMT_BGR:    pix = {8'h00, rgb[23:16], rgb[15:8], rgb[7:0]};
         default:                pix = {8'h00, rgb[7:0], rgb[15:8], rgb[23:16]};
      endcase
      return pix;
   endfunction

   function automatic pcxrle_pkg::rsp_type status_res(input pcxrle_pkg::kind_type kind,
                                                      input pcxrle_pkg::status_type code);
      pcxrle_pkg::rsp_type r;
      r             = '0;
      r.kind        = kind;
      r.status      = code;
      return r;
   endfunction

   assign accept    = req_valid && req_ready;
   assign rows_done = row_ff >= cfg.image_height;
   assign visible   = {1'b0, col_ff} < cfg.image_width;
   assign col_next  = col_ff + 16'd1;

   always_comb begin
      case (cfg.pixel_format)
         pcxrle_pkg::FMT_RGB565: col_bytes = {1'b0, col_ff, 1'b0};
         pcxrle_pkg::FMT_BGR:    col_bytes = {1'b0, col_ff, 1'b0} + {2'b00, col_ff};
         default:                col_bytes = {col_ff, 2'b00};
      endcase
   end

   always_comb begin
      pixel_res             = '0;
      pixel_res.kind        = pcxrle_pkg::KIND_PIXEL;
      pixel_res.pixel_bytes = format_pixel(rd_data, cfg.pixel_format);
      pixel_res.byte_count  = pcxrle_pkg::dest_pixel_bytes(cfg.pixel_format);
      pixel_res.row         = row_ff[15:0];
      pixel_res.column      = col_ff;
      pixel_res.byte_offset = base_ff + {14'd0, col_bytes};
      pixel_res.status      = pcxrle_pkg::STAT_NONE;
   end

   // A step yields a result unless it lands on a padding column.
   assign step_has_res = rows_done || visible;

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      base_in     = base_ff;
      await_in    = await_ff;
      run_in      = run_ff;
      remain_in   = remain_ff;
      sticky_in   = sticky_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      req_ready   = 1'b0;
      rd_en       = 1'b0;
      res_valid   = 1'b0;
      res         = hold_ff;

      unique case (state_ff)
         pcxrle_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               unique case (func)
                  pcxrle_pkg::FUNC_PALETTE: ;
                  pcxrle_pkg::FUNC_START: begin
                     row_in    = '0;
                     col_in    = '0;
                     base_in   = '0;
                     await_in  = 1'b0;
                     run_in    = '0;
                     sticky_in = cfg.geom_bad;
                     if (cfg.geom_bad) begin
                        hold_in     = status_res(pcxrle_pkg::KIND_ERROR,
                                                 pcxrle_pkg::STAT_BAD_GEOM);
                        hold_vld_in = 1'b1;
                        state_in    = pcxrle_pkg::S_FLUSH;
                     end
                  end
                  pcxrle_pkg::FUNC_DATA: begin
                     if (!sticky_ff) begin
                        if (await_ff) begin
                           await_in  = 1'b0;
                           rd_en     = 1'b1;
                           remain_in = run_ff;
                           state_in  = pcxrle_pkg::S_EXPAND;
                        end else if (rows_done) begin
                           hold_in     = status_res(pcxrle_pkg::KIND_ERROR,
                                                    pcxrle_pkg::STAT_EXTRA_DATA);
                           hold_vld_in = 1'b1;
                           sticky_in   = 1'b1;
                           state_in    = pcxrle_pkg::S_FLUSH;
                        end else if (data_byte[7:6] == 2'b11) begin
                           if (data_byte[5:0] == 6'd0) begin
                              hold_in     = status_res(pcxrle_pkg::KIND_ERROR,
                                                       pcxrle_pkg::STAT_ZERO_RUN);
                              hold_vld_in = 1'b1;
                              sticky_in   = 1'b1;
                              state_in    = pcxrle_pkg::S_FLUSH;
                           end else begin
                              run_in   = data_byte[pcxrle_pkg::RUN_W-1:0];
                              await_in = 1'b1;
                           end
                        end else begin
                           rd_en     = 1'b1;
                           remain_in = {{(pcxrle_pkg::RUN_W-1){1'b0}}, 1'b1};
                           state_in  = pcxrle_pkg::S_EXPAND;
                        end
                     end
                  end
                  pcxrle_pkg::FUNC_END: begin
                     if (!sticky_ff) begin
                        hold_vld_in = 1'b1;
                        state_in    = pcxrle_pkg::S_FLUSH;
                        if (await_ff) begin
                           hold_in   = status_res(pcxrle_pkg::KIND_ERROR,
                                                  pcxrle_pkg::STAT_CUT_RUN);
                           sticky_in = 1'b1;
                        end else if (!rows_done) begin
                           hold_in   = status_res(pcxrle_pkg::KIND_ERROR,
                                                  pcxrle_pkg::STAT_EARLY_END);
                           sticky_in = 1'b1;
                        end else begin
                           hold_in = status_res(pcxrle_pkg::KIND_DONE,
                                                pcxrle_pkg::STAT_NONE);
                        end
                     end
                  end
               endcase
            end
         end

         pcxrle_pkg::S_EXPAND: begin
            // A new result pushes the held one out, so it waits for a free slot.
            if (!(step_has_res && hold_vld_ff && !out_free)) begin
               if (step_has_res) begin
                  res_valid   = hold_vld_ff;
                  hold_vld_in = 1'b1;
               end
               if (rows_done) begin
                  hold_in   = status_res(pcxrle_pkg::KIND_ERROR, pcxrle_pkg::STAT_OVERRUN);
                  sticky_in = 1'b1;
                  state_in  = pcxrle_pkg::S_FLUSH;
               end else begin
                  if (visible) begin
                     hold_in = pixel_res;
                  end
                  if (col_next == cfg.src_line_bytes) begin
                     col_in  = '0;
                     row_in  = row_ff + 17'd1;
                     base_in = base_ff + {13'd0, cfg.dest_line_bytes};
                  end else begin
                     col_in = col_next;
                  end
                  remain_in = remain_ff - {{(pcxrle_pkg::RUN_W-1){1'b0}}, 1'b1};
                  if (remain_ff == {{(pcxrle_pkg::RUN_W-1){1'b0}}, 1'b1}) begin
                     state_in = pcxrle_pkg::S_FLUSH;
                  end
               end
            end
         end

         pcxrle_pkg::S_FLUSH: begin
            res.last = 1'b1;
            if (!hold_vld_ff) begin
               state_in = pcxrle_pkg::S_IDLE;
            end else if (out_free) begin
               res_valid   = 1'b1;
               hold_vld_in = 1'b0;
               state_in    = pcxrle_pkg::S_IDLE;
            end
         end

         default: state_in = pcxrle_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pcxrle_pkg::S_IDLE;
         row_ff      <= '0;
         col_ff      <= '0;
         base_ff     <= '0;
         await_ff    <= 1'b0;
         run_ff      <= '0;
         remain_ff   <= '0;
         sticky_ff   <= 1'b0;
         hold_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         base_ff     <= base_in;
         await_ff    <= await_in;
         run_ff      <= run_in;
         remain_ff   <= remain_in;
         sticky_ff   <= sticky_in;
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("result pushed while the output register is full");

   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcxrle_pkg::S_IDLE) |-> !hold_vld_ff)
      else $error("held result left behind when returning to idle");

   a_expand_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcxrle_pkg::S_EXPAND) |-> (remain_ff != '0))
      else $error("expansion running with no pixels left");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      await_ff |-> (run_ff != '0))
      else $error("waiting for a run value with a zero count");

endmodule

`default_nettype wire

// ===== rtl/core/pcx_rle_palette_pixel_decoder.sv =====
// Top level of the 8-bit PCX run-length palette decoder: stream ports,
// configuration registers, decode engine and the output register.
// Depends on pcxrle_pkg, pcxrle_csr, pcxrle_engine and pcxrle_ram.
//
// The block takes one request at a time on the req_ stream and answers on
// the rsp_ stream. A palette load, a start with good geometry, a run token or
// a request ignored after an error is taken in the idle state, which is then
// ready for the next request. A literal byte reads the 256-entry palette
// memory, steps the position counters in the expand state and releases its
// final result from the flush state. A run value with a count of N steps the
// same counters through N pixels, one pixel per cycle while the output
// register can take a result. A request that answers with a status result
// (bad geometry, a decode error or image complete) releases it from the flush
// state. The palette memory has a single read port. Results pass through a
// one-deep hold inside the engine, so the last result of each request can carry
// rsp_tlast, and then through an output register, so a waiting result does
// not block the next request. There is no clearing pass after reset: palette
// entries are defined only once loaded. Configuration registers may be
// written while no request is in flight; csr_ready is always high.
`default_nettype none

module pcx_rle_palette_pixel_decoder (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request stream.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // tdata, lowest bit up: data_byte[7:0], palette_index[15:8],
   // palette_rgb[39:16].
   input  wire logic [pcxrle_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: func[1:0].
   input  wire logic [1:0]                           req_tuser,
   // Result stream.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tdata, lowest bit up: pixel_bytes[31:0], byte_count[34:32], row[50:35],
   // column[66:51], byte_offset[98:67], status_code[101:99], zeros[103:102].
   output logic      [pcxrle_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // tuser: kind[1:0].
   output logic      [1:0]                           rsp_tuser,
   output logic                                      rsp_tlast,
   // Configuration write channel.
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [pcxrle_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [pcxrle_pkg::CSR_DATA_W-1:0]    csr_data
);

   pcxrle_pkg::cfg_type cfg;
   pcxrle_pkg::rsp_type res;
   pcxrle_pkg::rsp_type rsp_ff;
   logic                res_valid;
   logic                rsp_vld_ff;
   logic                out_free;

   pcxrle_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The output register can take a new result when empty or being drained.
   assign out_free = !rsp_vld_ff || rsp_tready;

   pcxrle_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .func          (pcxrle_pkg::func_type'(req_tuser)),
      .data_byte     (req_tdata[7:0]),
      .palette_index (req_tdata[15:8]),
      .palette_rgb   (req_tdata[39:16]),
      .cfg           (cfg),
      .out_free      (out_free),
      .res_valid     (res_valid),
      .res           (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {2'b00, rsp_ff.status, rsp_ff.byte_offset, rsp_ff.column,
                        rsp_ff.row, rsp_ff.byte_count, rsp_ff.pixel_bytes};

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the PCX run-length palette pixel decoder.
// Depends only on pcxrle_pkg and the pcx_rle_palette_pixel_decoder top level.
// A built-in predictor tracks palette, geometry and decode state per request.
module tb_top;
   import pcxrle_pkg::*;

   // Encoded byte classes: a byte with both top bits set is a run token.
   localparam logic [7:0] RUN_FLAGS   = 8'hC0;
   localparam logic [7:0] LITERAL_MAX = 8'hBF;
   localparam int RANDOM_REQUESTS = 150;
   // The slowest request is a run of 63 into padding, which yields no result;
   // waiting this many quiet cycles lets the block go idle.
   localparam int TAIL_CYCLES = 80;
   localparam int DRAIN_LIMIT = 20000;

   logic clock;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata = '0;
   logic [1:0]               req_tuser = FUNC_PALETTE;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic [1:0]               rsp_tuser;
   logic                     rsp_tlast;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   pcx_rle_palette_pixel_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Predictor copy of the configuration, starting at the reset values.
   logic [16:0] img_width   = 17'd1;
   logic [16:0] img_height  = 17'd1;
   logic [15:0] src_bytes   = 16'd1;
   logic [1:0]  pix_format  = FMT_RGB0;
   logic [18:0] dest_stride = 19'd4;

   // Predictor copy of the decode state. Reset leaves an image started.
   logic [23:0] pal_copy [0:PALETTE_ENTRIES-1];
   logic [16:0] rows_done     = '0;
   logic [15:0] col_pos       = '0;
   logic [31:0] row_base      = '0;
   logic        run_pending   = 1'b0;
   logic [5:0]  run_count     = '0;
   logic        decode_halted = 1'b0;

   // Results that the block still owes, oldest first.
   rsp_type decoded_q [$];

   int  error_total     = 0;
   int  active_requests = 0;
   bit  ignored_item;
   // When set, a side runs without idle cycles for a while.
   bit  req_calm = 1'b0;
   bit  rsp_calm = 1'b0;
   // Cycles the receiver still stalls before taking the next result, and a
   // one-shot long hold-off requested by the backpressure test.
   int  result_stall  = 0;
   int  hold_results  = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs on either stream.
   initial begin
      #(12 * 3_000_000);
      $display("tb_top failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Bytes per destination pixel; the unused format code acts as RGB0.
   function automatic logic [2:0] pixel_size();
      case (pix_format)
         FMT_RGB565: return 3'd2;
         FMT_BGR:    return 3'd3;
         default:    return 3'd4;
      endcase
   endfunction

   function automatic logic [31:0] shade_bytes(input logic [23:0] rgb);
      logic [7:0] red, green, blue;
      red   = rgb[23:16];
      green = rgb[15:8];
      blue  = rgb[7:0];
      case (pix_format)
         FMT_RGB565: return {16'd0, red[7:3], green[7:2], blue[7:3]};
         FMT_BGR:    return {8'd0, red, green, blue};
         default:    return {8'd0, blue, green, red};
      endcase
   endfunction

   function automatic bit geometry_bad();
      return img_width == 17'd0 || img_width > 17'd65536 ||
             img_height == 17'd0 || img_height > 17'd65536 ||
             src_bytes == 16'd0 || {1'b0, src_bytes} < img_width ||
             pix_format == FMT_BAD ||
             32'(img_width) * 32'(pixel_size()) > 32'(dest_stride);
   endfunction

   // Any error result stops decoding until the next start.
   task automatic flag_error(input status_type code);
      rsp_type r;
      r = '0;
      r.kind = KIND_ERROR;
      r.status = code;
      decoded_q.push_back(r);
      decode_halted = 1'b1;
   endtask

   // Emits count pixels of one palette value, skipping padding columns and
   // stopping with an overrun once every row is filled.
   task automatic emit_run(input int count, input logic [7:0] value);
      int i;
      rsp_type r;
      logic [31:0] bpp;
      bpp = 32'(pixel_size());
      for (i = 0; i < count; i++) begin
         if (rows_done >= img_height) begin
            flag_error(STAT_OVERRUN);
            return;
         end
         if ({1'b0, col_pos} < img_width) begin
            r = '0;
            r.kind = KIND_PIXEL;
            r.pixel_bytes = shade_bytes(pal_copy[value]);
            r.byte_count = bpp[2:0];
            r.row = rows_done[15:0];
            r.column = col_pos;
            r.byte_offset = row_base + 32'(col_pos) * bpp;
            r.status = STAT_NONE;
            decoded_q.push_back(r);
         end
         col_pos = col_pos + 16'd1;
         // A zero line length matches only after the 16-bit counter wraps.
         if (col_pos == src_bytes) begin
            col_pos = '0;
            rows_done = rows_done + 17'd1;
            row_base = row_base + 32'(dest_stride);
         end
      end
   endtask

   // Updates the predictor for one accepted request and queues its results.
   task automatic decode_request(input func_type func, input logic [7:0] data_byte,
                                 input logic [7:0] index, input logic [23:0] rgb);
      int before_n;
      rsp_type r;
      before_n = decoded_q.size();
      ignored_item = 1'b0;
      case (func)
         FUNC_PALETTE: pal_copy[index] = rgb;
         FUNC_START: begin
            rows_done = '0;
            col_pos = '0;
            row_base = '0;
            run_pending = 1'b0;
            run_count = '0;
            decode_halted = 1'b0;
            if (geometry_bad())
               flag_error(STAT_BAD_GEOM);
         end
         default: begin
            if (decode_halted) begin
               ignored_item = 1'b1;
            end else if (func == FUNC_DATA) begin
               if (run_pending) begin
                  run_pending = 1'b0;
                  emit_run(run_count, data_byte);
               end else if (rows_done >= img_height) begin
                  flag_error(STAT_EXTRA_DATA);
               end else if ((data_byte & RUN_FLAGS) == RUN_FLAGS) begin
                  if (data_byte[5:0] == 6'd0) begin
                     flag_error(STAT_ZERO_RUN);
                  end else begin
                     run_count = data_byte[5:0];
                     run_pending = 1'b1;
                  end
               end else begin
                  emit_run(1, data_byte);
               end
            end else begin
               if (run_pending) begin
                  flag_error(STAT_CUT_RUN);
               end else if (rows_done < img_height) begin
                  flag_error(STAT_EARLY_END);
               end else begin
                  r = '0;
                  r.kind = KIND_DONE;
                  r.status = STAT_NONE;
                  decoded_q.push_back(r);
               end
            end
         end
      endcase
      // The final result of a request carries tlast.
      if (decoded_q.size() > before_n) begin
         r = decoded_q.pop_back();
         r.last = 1'b1;
         decoded_q.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall pattern and checking
   // ---------------------------------------------------------------------

   // Ready changes only at falling edges. A long hold-off replaces the
   // current stall and is counted down here, cycle by cycle.
   always @(negedge clock) begin
      if (hold_results > 0) begin
         result_stall = hold_results;
         hold_results = 0;
      end
      rsp_tready <= (result_stall == 0);
      if (result_stall > 0)
         result_stall--;
   end

   task automatic compare_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
         error_total++;
      end
   endtask

   // Every accepted result is matched against the oldest outstanding one.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_q.size() == 0) begin
            $error("result with nothing outstanding: kind %0d tdata 0x%0h",
                   rsp_tuser, rsp_tdata);
            error_total++;
         end else begin
            want = decoded_q.pop_front();
            compare_field("kind", 32'(want.kind), 32'(rsp_tuser));
            compare_field("pixel_bytes", want.pixel_bytes, rsp_tdata[31:0]);
            compare_field("byte_count", 32'(want.byte_count), 32'(rsp_tdata[34:32]));
            compare_field("row", 32'(want.row), 32'(rsp_tdata[50:35]));
            compare_field("column", 32'(want.column), 32'(rsp_tdata[66:51]));
            compare_field("byte_offset", want.byte_offset, rsp_tdata[98:67]);
            compare_field("status_code", 32'(want.status), 32'(rsp_tdata[101:99]));
            compare_field("tdata padding", 32'd0, 32'(rsp_tdata[103:102]));
            compare_field("last", 32'(want.last), 32'(rsp_tlast));
         end
         result_stall = rsp_calm ? 0 : $urandom_range(0, 9);
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offers one request after a random idle gap and waits for its handshake.
   // Valid stays high afterwards so back-to-back requests need no extra edge;
   // settle() lowers it whenever the stream is to go quiet.
   task automatic send_request(input func_type func, input logic [7:0] data_byte,
                               input logic [7:0] index, input logic [23:0] rgb);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {rgb, index, data_byte};
      do @(posedge clock); while (!req_tready);
      decode_request(func, data_byte, index, rgb);
      if (!ignored_item)
         active_requests++;
   endtask

   task automatic send_byte(input logic [7:0] data_byte);
      send_request(FUNC_DATA, data_byte, 8'($urandom), 24'($urandom));
   endtask

   task automatic send_run(input int count, input logic [7:0] value);
      send_byte(RUN_FLAGS | 8'(count));
      send_byte(value);
   endtask

   task automatic send_start();
      send_request(FUNC_START, 8'($urandom), 8'($urandom), 24'($urandom));
   endtask

   task automatic send_end();
      send_request(FUNC_END, 8'($urandom), 8'($urandom), 24'($urandom));
   endtask

   // Stops offering requests, waits until every owed result has arrived and
   // then lets the block finish any request that produces no result.
   task automatic settle();
      int waited;
      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (decoded_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (decoded_q.size() != 0) begin
         $error("%0d results never arrived", decoded_q.size());
         error_total++;
         decoded_q.delete();
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_IMAGE_WIDTH:     img_width = value[16:0];
         CSR_IMAGE_HEIGHT:    img_height = value[16:0];
         CSR_SRC_LINE_BYTES:  src_bytes = value[15:0];
         CSR_PIXEL_FORMAT:    pix_format = value[1:0];
         CSR_DEST_LINE_BYTES: dest_stride = value[18:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_geometry(input int width, input int height, input int src,
                               input int format, input int dest);
      settle();
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(width));
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(height));
      write_register(CSR_SRC_LINE_BYTES, CSR_DATA_W'(src));
      write_register(CSR_PIXEL_FORMAT, CSR_DATA_W'(format));
      write_register(CSR_DEST_LINE_BYTES, CSR_DATA_W'(dest));
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Loads every palette entry so that no pixel ever reads an unwritten one.
   // The first entry is full white and the last is black.
   task automatic fill_palette();
      int i;
      logic [23:0] rgb;
      for (i = 0; i < PALETTE_ENTRIES; i++) begin
         rgb = (i == 0) ? 24'hFFFFFF : (i == PALETTE_ENTRIES - 1) ? 24'h000000
                                                                  : 24'($urandom);
         send_request(FUNC_PALETTE, 8'($urandom), 8'(i), rgb);
      end
   endtask

   // Reset leaves a started 1x1 RGB0 image, so data decodes without a start.
   // Repeated ends after completion repeat the completion result, and data
   // past the last row is an error that silences everything up to a start.
   task automatic test_reset_geometry();
      send_byte(8'h05);
      send_end();
      send_end();
      send_byte(8'h10);
      send_byte(8'h11);
      send_end();
      send_start();
      send_byte(LITERAL_MAX);
      send_end();
   endtask

   // Each format with a padding column and a run that spans its own row.
   task automatic test_formats();
      int fmt;
      for (fmt = 0; fmt < 3; fmt++) begin
         set_geometry(2, 2, 3, fmt, 2 * (fmt + 2) + 1);
         send_start();
         send_byte(8'h00);
         send_byte(LITERAL_MAX);
         send_byte(8'h7F);
         send_run(2, 8'hFF);
         send_byte(8'h40);
         send_end();
      end
   endtask

   // Zero run, overrun, cut run, early end and extra data.
   task automatic test_run_errors();
      set_geometry(3, 2, 3, FMT_RGB0, 12);
      send_start();
      // A run value may itself look like a run token.
      send_run(3, 8'hC3);
      send_byte(RUN_FLAGS);
      send_byte(8'h01);
      send_start();
      // Six pixels fit, then the rest of the run overruns the image.
      send_run(63, 8'h80);
      send_start();
      send_byte(RUN_FLAGS | 8'd5);
      send_end();
      send_start();
      send_byte(8'h2A);
      send_end();
      send_start();
      send_run(6, 8'h01);
      send_byte(8'h02);
   endtask

   // Every way a start can reject the geometry. While the error holds, data
   // and end are dropped but palette loads still take effect.
   task automatic test_bad_geometry();
      int c;
      int cases [9][5] = '{
         '{0,      1,      1,     FMT_RGB0,   4},
         '{65536,  1,      65535, FMT_RGB565, 262144},
         '{131071, 1,      65535, FMT_RGB0,   262144},
         '{1,      0,      1,     FMT_RGB0,   4},
         '{1,      131071, 1,     FMT_RGB0,   4},
         '{1,      1,      0,     FMT_RGB0,   4},
         '{4,      1,      3,     FMT_RGB0,   16},
         '{1,      1,      1,     FMT_BAD,    4},
         '{2,      1,      2,     FMT_BGR,    5}
      };
      for (c = 0; c < 9; c++) begin
         set_geometry(cases[c][0], cases[c][1], cases[c][2], cases[c][3], cases[c][4]);
         send_start();
         send_byte(8'h22);
         send_end();
      end
      send_request(FUNC_PALETTE, 8'h00, 8'h22, 24'h123456);
      // Stride exactly equal to the row width in bytes is still good.
      set_geometry(2, 1, 2, FMT_BGR, 6);
      send_start();
      send_run(2, 8'h22);
      send_end();
   endtask

   // Registers act live on a running image: format, stride and height are
   // used as they stand when each pixel is decoded.
   task automatic test_live_registers();
      set_geometry(2, 3, 2, FMT_RGB565, 4);
      send_start();
      send_byte(8'h01);
      send_byte(8'h02);
      settle();
      write_register(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_BAD));
      send_byte(8'h03);
      settle();
      write_register(CSR_DEST_LINE_BYTES, CSR_DATA_W'(100));
      send_byte(8'h04);
      settle();
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(1));
      send_byte(8'h05);
   endtask

   // The largest geometry, and a stride of 262144 bytes over several rows.
   task automatic test_extremes();
      set_geometry(65535, 65536, 65535, FMT_RGB565, 262144);
      send_start();
      send_run(63, 8'hFF);
      send_byte(8'h00);
      send_end();
      set_geometry(1, 3, 1, FMT_RGB0, 262144);
      send_start();
      send_run(5, 8'h80);
   endtask

   // The receiver holds off for a long time while the sender keeps offering,
   // so the block backs up and stalls its input. The sender then pauses
   // until every result has been taken.
   task automatic test_backpressure();
      int i;
      set_geometry(4, 8, 4, FMT_BGR, 12);
      send_start();
      req_calm = 1'b1;
      hold_results = 400;
      for (i = 0; i < 8; i++)
         send_run(4, 8'($urandom));
      send_end();
      settle();
      req_calm = 1'b0;
   endtask

   // Mostly well-formed images with random content and geometry, mixed with
   // truncated, broken and overlong streams and the odd stray request.
   task automatic test_random_images();
      int width, height, src, fmt, flaw, left, n, target;
      bit fresh;
      fresh = 1'b1;
      target = active_requests + RANDOM_REQUESTS;
      while (active_requests < target) begin
         req_calm = ($urandom_range(0, 4) == 0);
         rsp_calm = ($urandom_range(0, 4) == 0);
         if (fresh || $urandom_range(0, 2) != 0) begin
            width = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            src = width + $urandom_range(0, 3);
            height = $urandom_range(1, 4);
            fmt = $urandom_range(0, 2);
            set_geometry(width, height, src, fmt, width * (fmt + 2) + $urandom_range(0, 4));
            fresh = 1'b0;
         end
         send_start();
         flaw = $urandom_range(0, 19);
         left = int'(src_bytes) * int'(img_height);
         // Flaw 0 stops short of the last row.
         if (flaw == 0)
            left = $urandom_range(0, left - 1);
         while (left > 0) begin
            if ($urandom_range(0, 29) == 0)
               send_request(FUNC_PALETTE, 8'($urandom), 8'($urandom), 24'($urandom));
            if ($urandom_range(0, 59) == 0)
               send_request(func_type'(2'($urandom_range(0, 3))), 8'($urandom),
                            8'($urandom), 24'($urandom));
            // Flaw 1 drops in a zero-length run token.
            if (flaw == 1 && $urandom_range(0, 9) == 0)
               send_byte(RUN_FLAGS);
            if ($urandom_range(0, 2) == 0) begin
               send_byte(8'($urandom_range(0, LITERAL_MAX)));
               left--;
            end else begin
               n = $urandom_range(1, (left < MAX_RUN) ? left : MAX_RUN);
               // Flaw 2 lets a run spill past the last row.
               if (flaw == 2)
                  n = $urandom_range(n, MAX_RUN);
               send_run(n, 8'($urandom_range(0, 255)));
               left -= n;
            end
         end
         case (flaw)
            3: send_byte(RUN_FLAGS | 8'($urandom_range(1, MAX_RUN)));
            4: send_byte(8'($urandom));
            default: ;
         endcase
         send_end();
         if ($urandom_range(0, 3) == 0)
            send_end();
      end
      req_calm = 1'b0;
      rsp_calm = 1'b0;
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      fill_palette();
      test_reset_geometry();
      test_formats();
      test_run_errors();
      test_bad_geometry();
      test_live_registers();
      test_extremes();
      test_random_images();
      test_backpressure();
      settle();
      if (error_total == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
